// File: hdl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 4;

  typedef enum logic [1:0] {
    OP_APPEND     = 2'd0,
    OP_POP_OLDEST = 2'd1,
    OP_POP_NEWEST = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // popped value after reset or clear: -1
  localparam logic [WORD_W-1:0] POPPED_INIT = '1;

endpackage

// File: hdl/rbd_mem.sv
// ----------------------------------------------------------------------------
// rbd_mem
// Slot store: one write port, two registered read ports with write bypass.
// ----------------------------------------------------------------------------
module rbd_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rbd_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [rbd_pkg::WORD_W-1:0] rdata_a,
  output logic [rbd_pkg::WORD_W-1:0] rdata_b
);

  logic [rbd_pkg::WORD_W-1:0] mem [DEPTH];
  logic [rbd_pkg::WORD_W-1:0] rdata_a_r;
  logic [rbd_pkg::WORD_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data follows a write to the same slot in the same cycle
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr_a)) begin
      rdata_a_r <= wdata;
    end else begin
      rdata_a_r <= mem[raddr_a];
    end
    if (we && (waddr == raddr_b)) begin
      rdata_b_r <= wdata;
    end else begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: hdl/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Circular queue of signed words with append, pop oldest, pop newest, clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per word. in_tuser carries the op code, in_tdata
//           the value to append (ignored by the other ops).
//   out_* : one result word per operation, in order: status in out_tuser,
//           item count and last popped value in out_tdata.
// One operation is taken every cycle while the output is not stalled. The
// word is held in an input register, then the index update and the slot
// store access complete as the result enters the output register. The slot
// store keeps registered reads of the head slot and the slot before the tail,
// addressed by the next indices, so both pop candidates are ready when the
// next operation arrives.
// Reset empties the queue and sets the popped value to -1; stored words are
// not cleared. When out_tready is low the result is held, one more
// operation waits in the input register, and in_tready then drops.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
  parameter int CAPACITY = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata : [31:0] value
  input  logic [31:0] in_tdata,
  // in_tuser : [1:0] op
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata : [3:0] item_count, [35:4] popped_value, [39:36] zero
  output logic [39:0] out_tdata,
  // out_tuser : [0] status
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int SLOTS = CAPACITY + 1;
  localparam int IW    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int WW    = rbd_pkg::WORD_W;
  localparam int CW    = rbd_pkg::COUNT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY);

  // input register
  logic              s1_valid_r;
  rbd_pkg::op_t      s1_op_r;
  logic [WW-1:0]     s1_value_r;

  // queue state
  logic [IW-1:0]     head_r,   head_nxt;
  logic [IW-1:0]     tail_r,   tail_nxt;
  logic [IW-1:0]     occ_r,    occ_nxt;
  logic [WW-1:0]     popped_r, popped_nxt;
  logic              status_nxt;

  // result register
  logic              out_valid_r;
  logic              out_status_r;
  logic [CW-1:0]     out_count_r;
  logic [WW-1:0]     out_popped_r;

  logic              advance;
  logic              mem_we;
  logic [WW-1:0]     rd_head;
  logic [WW-1:0]     rd_last;
  logic [IW-1:0]     tail_next_slot;
  logic [IW-1:0]     tail_prev_slot;
  logic [IW-1:0]     head_next_slot;
  logic [IW-1:0]     rd_last_addr;
  logic              is_empty;
  logic              is_full;
  logic [IW+CW-1:0]  count_ext;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= rbd_pkg::op_t'(in_tuser);
      s1_value_r <= in_tdata;
    end
  end

  assign tail_next_slot = (tail_r == LAST_SLOT) ? '0 : tail_r + IW'(1);
  assign tail_prev_slot = (tail_r == '0) ? LAST_SLOT : tail_r - IW'(1);
  assign head_next_slot = (head_r == LAST_SLOT) ? '0 : head_r + IW'(1);
  assign is_empty       = (head_r == tail_r);
  assign is_full        = (tail_next_slot == head_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    popped_nxt = popped_r;
    status_nxt = rbd_pkg::STATUS_DONE;
    mem_we     = 1'b0;
    if (advance) begin
      unique case (s1_op_r)
        rbd_pkg::OP_APPEND: begin
          if (is_full) begin
            status_nxt = rbd_pkg::STATUS_REFUSED;
          end else begin
            mem_we   = 1'b1;
            tail_nxt = tail_next_slot;
            occ_nxt  = occ_r + IW'(1);
          end
        end
        rbd_pkg::OP_POP_OLDEST: begin
          if (is_empty) begin
            status_nxt = rbd_pkg::STATUS_REFUSED;
          end else begin
            popped_nxt = rd_head;
            head_nxt   = head_next_slot;
            occ_nxt    = occ_r - IW'(1);
          end
        end
        rbd_pkg::OP_POP_NEWEST: begin
          if (is_empty) begin
            status_nxt = rbd_pkg::STATUS_REFUSED;
          end else begin
            popped_nxt = rd_last;
            tail_nxt   = tail_prev_slot;
            occ_nxt    = occ_r - IW'(1);
          end
        end
        rbd_pkg::OP_CLEAR: begin
          head_nxt   = '0;
          tail_nxt   = '0;
          occ_nxt    = '0;
          popped_nxt = rbd_pkg::POPPED_INIT;
        end
        default: begin
          status_nxt = rbd_pkg::STATUS_DONE;
        end
      endcase
    end
  end

  // slot just before the next tail, i.e. the newest item after this update
  assign rd_last_addr = (tail_nxt == '0) ? LAST_SLOT : tail_nxt - IW'(1);

  rbd_mem #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (tail_r),
    .wdata   (s1_value_r),
    .raddr_a (head_nxt),
    .raddr_b (rd_last_addr),
    .rdata_a (rd_head),
    .rdata_b (rd_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      popped_r <= rbd_pkg::POPPED_INIT;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      popped_r <= popped_nxt;
    end
  end

  // count reported modulo 16
  assign count_ext = {{CW{1'b0}}, occ_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_ext[CW-1:0];
      out_popped_r <= popped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000, out_popped_r, out_count_r};

endmodule
